/* sv/stuffed_packet_framer_core_defines.svh */
// assertion macros for the stuffed packet framer core
// used by the top level only; expects clk and arst_n in scope
`ifndef STUFFED_PACKET_FRAMER_CORE_DEFINES_SVH
`define STUFFED_PACKET_FRAMER_CORE_DEFINES_SVH

// same-cycle implication, idle during reset
`define SPF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spf: same-cycle check failed");

// next-cycle implication, idle during reset
`define SPF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spf: next-cycle check failed");

`endif

/* sv/spf_pkg.sv */
// shared types, codes and constants for the stuffed packet framer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

	localparam int PC_W = 4;
	localparam int CNT_W = 6;

	localparam logic [CNT_W-1:0] MAX_SEGMENT = 6'd48;

	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] SEP_RESET = 8'h2D;

	typedef enum logic [1:0] {
		MODE_HDR = 2'd0,
		MODE_DATA = 2'd1,
		MODE_END = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	// byte source select
	typedef enum logic [3:0] {
		SRC_PN3,
		SRC_PN2,
		SRC_PN1,
		SRC_PN0,
		SRC_PID,
		SRC_ZERO,
		SRC_SIZE,
		SRC_DATA,
		SRC_XOR,
		SRC_SEP
	} src_t;

	typedef enum logic [1:0] {
		XOP_NONE,
		XOP_LOAD,
		XOP_FOLD
	} xop_t;

	typedef enum logic [1:0] {
		COP_NONE,
		COP_CLEAR,
		COP_INC
	} cop_t;

	typedef enum logic {
		JMP_NEXT,
		JMP_PAD
	} jmp_t;

	// one control word of the microprogram
	typedef struct packed {
		src_t src;
		logic emit;
		logic stuff;
		logic last;
		logic frame_end;
		logic done;
		xop_t xop;
		cop_t cop;
		logic size_ld;
		logic pad_ld;
		jmp_t jmp;
	} cw_t;

	// sequencer to datapath
	typedef struct packed {
		logic active;
		cw_t cw;
	} ctl_t;

	// datapath to sequencer
	typedef struct packed {
		logic step_done;
		logic esc_pend;
	} stat_t;

	// program entry points
	localparam logic [PC_W-1:0] PC_HDR = 4'd0;
	localparam logic [PC_W-1:0] PC_DATA = 4'd9;
	localparam logic [PC_W-1:0] PC_END = 4'd10;

endpackage

`default_nettype wire

/* sv/spf_ucode_rom.sv */
// microprogram table of the framer: one control word per step
// depends on spf_pkg
`timescale 1ns / 1ps
`default_nettype none

module spf_ucode_rom (
	input wire logic [spf_pkg::PC_W-1:0] pc,
	output spf_pkg::cw_t cw
);

	// program: header 0..8, data 9, end 10..13
	always_comb begin
		cw = '{src: spf_pkg::SRC_ZERO, emit: 1'b0, stuff: 1'b0, last: 1'b0,
			frame_end: 1'b0, done: 1'b1, xop: spf_pkg::XOP_NONE,
			cop: spf_pkg::COP_NONE, size_ld: 1'b0, pad_ld: 1'b0,
			jmp: spf_pkg::JMP_NEXT};
		case (pc)
			4'd0: begin
				cw.src = spf_pkg::SRC_PN3;
				cw.emit = 1'b1;
				cw.stuff = 1'b1;
				cw.done = 1'b0;
				cw.xop = spf_pkg::XOP_LOAD;
				cw.cop = spf_pkg::COP_CLEAR;
				cw.size_ld = 1'b1;
			end
			4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7: begin
				case (pc)
					4'd1: cw.src = spf_pkg::SRC_PN2;
					4'd2: cw.src = spf_pkg::SRC_PN1;
					4'd3: cw.src = spf_pkg::SRC_PN0;
					4'd4: cw.src = spf_pkg::SRC_PID;
					default: cw.src = spf_pkg::SRC_ZERO;
				endcase
				cw.emit = 1'b1;
				cw.stuff = 1'b1;
				cw.done = 1'b0;
				cw.xop = spf_pkg::XOP_FOLD;
			end
			4'd8: begin
				cw.src = spf_pkg::SRC_SIZE;
				cw.emit = 1'b1;
				cw.stuff = 1'b1;
				cw.last = 1'b1;
				cw.xop = spf_pkg::XOP_FOLD;
			end
			4'd9: begin
				cw.src = spf_pkg::SRC_DATA;
				cw.emit = 1'b1;
				cw.stuff = 1'b1;
				cw.last = 1'b1;
				cw.xop = spf_pkg::XOP_FOLD;
				cw.cop = spf_pkg::COP_INC;
			end
			4'd10: begin
				cw.done = 1'b0;
				cw.pad_ld = 1'b1;
			end
			4'd11: begin
				cw.src = spf_pkg::SRC_ZERO;
				cw.emit = 1'b1;
				cw.done = 1'b0;
				cw.jmp = spf_pkg::JMP_PAD;
			end
			4'd12: begin
				cw.src = spf_pkg::SRC_XOR;
				cw.emit = 1'b1;
				cw.stuff = 1'b1;
				cw.done = 1'b0;
			end
			4'd13: begin
				cw.src = spf_pkg::SRC_SEP;
				cw.emit = 1'b1;
				cw.last = 1'b1;
				cw.frame_end = 1'b1;
			end
			default: begin
				cw.done = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/spf_sequencer.sv */
// step counter and dispatch of the framer microprogram
// depends on spf_pkg and spf_ucode_rom
`timescale 1ns / 1ps
`default_nettype none

module spf_sequencer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [1:0] mode,
	input wire spf_pkg::stat_t stat,
	output spf_pkg::ctl_t ctl
);

	logic [spf_pkg::PC_W-1:0] pc_q;
	logic busy_q;
	logic [spf_pkg::PC_W-1:0] entry;
	spf_pkg::cw_t cw;

	spf_ucode_rom u_rom (
		.pc(pc_q),
		.cw(cw)
	);

	// entry point by item mode
	always_comb begin
		case (spf_pkg::mode_t'(mode))
			spf_pkg::MODE_HDR: entry = spf_pkg::PC_HDR;
			spf_pkg::MODE_DATA: entry = spf_pkg::PC_DATA;
			spf_pkg::MODE_END: entry = spf_pkg::PC_END;
			default: entry = spf_pkg::PC_HDR;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			pc_q <= entry;
			busy_q <= (spf_pkg::mode_t'(mode) != spf_pkg::MODE_NONE);
		end else if (busy_q && stat.step_done) begin
			if (cw.done) begin
				busy_q <= 1'b0;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	assign ctl.active = busy_q;
	assign ctl.cw = cw;

endmodule

`default_nettype wire

/* sv/spf_datapath.sv */
// framer datapath: item hold, checksum and count state, stuffing, output word register
// depends on spf_pkg
`timescale 1ns / 1ps
`default_nettype none

module spf_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load,
	input wire logic [31:0] packet_number,
	input wire logic [7:0] packet_id,
	input wire logic [5:0] segment_size,
	input wire logic [7:0] data_byte,
	input wire logic [7:0] sep,
	input wire spf_pkg::ctl_t ctl,
	output spf_pkg::stat_t stat,
	output logic res_valid,
	input wire logic res_ready,
	output logic [7:0] out_byte,
	output logic last,
	output logic frame_end
);

	logic [31:0] pn_q;
	logic [7:0] pid_q;
	logic [5:0] ssz_q;
	logic [7:0] db_q;
	logic [7:0] xor_q;
	logic [spf_pkg::CNT_W-1:0] cnt_q;
	logic [spf_pkg::CNT_W-1:0] decl_q;
	logic [spf_pkg::CNT_W-1:0] pad_q;
	logic esc_q;
	logic valid_q;
	logic [7:0] byte_q;
	logic last_q;
	logic fe_q;

	logic [7:0] sel;
	logic [spf_pkg::CNT_W-1:0] pad_lim;
	logic pad_more;
	logic pad_stay;
	logic emit;
	logic need_esc;
	logic out_free;
	logic stall;
	logic fire;
	logic esc_first;
	logic step_done;
	logic [7:0] nxt_byte;
	logic nxt_last;
	logic nxt_fe;

	// hold the accepted item
	always_ff @(posedge clk) begin
		if (load) begin
			pn_q <= packet_number;
			pid_q <= packet_id;
			ssz_q <= segment_size;
			db_q <= data_byte;
		end
	end

	// byte source mux
	always_comb begin
		case (ctl.cw.src)
			spf_pkg::SRC_PN3: sel = pn_q[31:24];
			spf_pkg::SRC_PN2: sel = pn_q[23:16];
			spf_pkg::SRC_PN1: sel = pn_q[15:8];
			spf_pkg::SRC_PN0: sel = pn_q[7:0];
			spf_pkg::SRC_PID: sel = pid_q;
			spf_pkg::SRC_SIZE: sel = {2'b00, ssz_q};
			spf_pkg::SRC_DATA: sel = db_q;
			spf_pkg::SRC_XOR: sel = xor_q;
			spf_pkg::SRC_SEP: sel = sep;
			default: sel = 8'h00;
		endcase
	end

	// padding limit and step conditions
	always_comb begin
		pad_lim = (decl_q > spf_pkg::MAX_SEGMENT) ? spf_pkg::MAX_SEGMENT : decl_q;
		pad_more = (pad_q < pad_lim);
		pad_stay = (ctl.cw.jmp == spf_pkg::JMP_PAD) && pad_more;
		emit = ctl.active && ctl.cw.emit &&
			!((ctl.cw.jmp == spf_pkg::JMP_PAD) && !pad_more);
		need_esc = ctl.cw.stuff && ((sel == spf_pkg::CH_DASH) || (sel == spf_pkg::CH_QUEST));
		out_free = !valid_q || res_ready;
		stall = emit && !out_free;
		fire = emit && out_free;
		esc_first = emit && need_esc && !esc_q;
		step_done = ctl.active && !stall && !esc_first && !pad_stay;
	end

	// stuffing: escape mark first, then the mapped byte
	always_comb begin
		if (need_esc && !esc_q) begin
			nxt_byte = spf_pkg::CH_QUEST;
			nxt_last = 1'b0;
			nxt_fe = 1'b0;
		end else if (need_esc) begin
			nxt_byte = (sel == spf_pkg::CH_DASH) ? spf_pkg::CH_DASH : spf_pkg::CH_STAR;
			nxt_last = ctl.cw.last;
			nxt_fe = ctl.cw.frame_end;
		end else begin
			nxt_byte = sel;
			nxt_last = ctl.cw.last;
			nxt_fe = ctl.cw.frame_end;
		end
	end

	// checksum, count, size and padding state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q <= 8'h00;
			cnt_q <= '0;
			decl_q <= '0;
			pad_q <= '0;
			esc_q <= 1'b0;
		end else begin
			if (fire && need_esc) begin
				esc_q <= !esc_q;
			end
			if (ctl.active && !stall && pad_stay) begin
				pad_q <= pad_q + 1'b1;
			end
			if (step_done) begin
				case (ctl.cw.xop)
					spf_pkg::XOP_LOAD: xor_q <= sel;
					spf_pkg::XOP_FOLD: xor_q <= xor_q ^ sel;
					default: xor_q <= xor_q;
				endcase
				case (ctl.cw.cop)
					spf_pkg::COP_CLEAR: cnt_q <= '0;
					spf_pkg::COP_INC: begin
						if (cnt_q < spf_pkg::MAX_SEGMENT) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					default: cnt_q <= cnt_q;
				endcase
				if (ctl.cw.size_ld) begin
					decl_q <= ssz_q;
				end
				if (ctl.cw.pad_ld) begin
					pad_q <= cnt_q;
				end
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q <= nxt_byte;
			last_q <= nxt_last;
			fe_q <= nxt_fe;
		end
	end

	assign stat.step_done = step_done;
	assign stat.esc_pend = esc_q;
	assign res_valid = valid_q;
	assign out_byte = byte_q;
	assign last = last_q;
	assign frame_end = fe_q;

endmodule

`default_nettype wire

/* sv/stuffed_packet_framer_core.sv */
// Stuffed packet framer core.
// Input channel item_valid/item_ready carries one item: mode 0 header
// (packet_number, packet_id, segment_size), mode 1 data byte, mode 2 end
// of frame, mode 3 accepted and dropped. Output channel res_valid/res_ready
// carries one encoded word per handshake (out_byte, last, frame_end);
// last marks the final word of an item, frame_end the separator.
// The separator register is written through cfg_we/cfg_wdata, reset '-'.
// A microprogram steps through one item at a time; a step that escapes a
// '-' or '?' emits the escape mark '?' and then the mapped byte. The first
// word of an item passes the step counter and then the output register.
// A header emits packet_number, packet_id, three zero bytes and
// segment_size; an end item emits zero padding up to the declared size
// (at most 48), the checksum and the separator. Item rate is set by the
// single output word register, one word per cycle while res_ready is high.
// item_ready is high whenever the sequencer is idle, even while the last
// word of the previous item still sits in the output register.
// Reset clears checksum, data count and declared size to zero and
// empties the output register. A stalled receiver freezes the sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "stuffed_packet_framer_core_defines.svh"

module stuffed_packet_framer_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_ready,
	input wire logic [1:0] mode,
	input wire logic [31:0] packet_number,
	input wire logic [7:0] packet_id,
	input wire logic [5:0] segment_size,
	input wire logic [7:0] data_byte,
	output logic res_valid,
	input wire logic res_ready,
	output logic [7:0] out_byte,
	output logic last,
	output logic frame_end,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_wdata
);

	logic [7:0] sep_q;
	logic start;
	spf_pkg::ctl_t ctl;
	spf_pkg::stat_t stat;

	// separator register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= spf_pkg::SEP_RESET;
		end else if (cfg_we) begin
			sep_q <= cfg_wdata;
		end
	end

	// input handshake
	assign item_ready = !ctl.active;
	assign start = item_valid && item_ready;

	spf_sequencer u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.mode(mode),
		.stat(stat),
		.ctl(ctl)
	);

	spf_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.load(start),
		.packet_number(packet_number),
		.packet_id(packet_id),
		.segment_size(segment_size),
		.data_byte(data_byte),
		.sep(sep_q),
		.ctl(ctl),
		.stat(stat),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.out_byte(out_byte),
		.last(last),
		.frame_end(frame_end)
	);

	// checks
	`SPF_ASSERT_NOW(a_fe_is_last, res_valid && frame_end, last)
	`SPF_ASSERT_NOW(a_esc_in_step, stat.esc_pend, ctl.active)
	`SPF_ASSERT_NEXT(a_item_starts, start && (mode != spf_pkg::MODE_NONE), ctl.active)

endmodule

`default_nettype wire
